[src/lsb_payload_extractor_top_assert.svh]
// assertion macros shared by the lsb payload extractor modules
`ifndef LSB_PAYLOAD_EXTRACTOR_TOP_ASSERT_SVH
`define LSB_PAYLOAD_EXTRACTOR_TOP_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define LPE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define LPE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/lpe_pkg.sv]
// types and constants of the lsb payload extractor
`timescale 1ns / 1ps

package lpe_pkg;

  localparam logic [1:0] MODE_1BIT = 2'd1;
  localparam logic [1:0] MODE_2BIT = 2'd2;
  localparam logic [1:0] MODE_3BIT = 2'd3;

  localparam int unsigned FIFO_DEPTH = 4;

  localparam logic [2:0] GROUP_END_4 = 3'd3;
  localparam logic [2:0] GROUP_END_8 = 3'd7;
  localparam logic [4:0] HDR_END_32  = 5'd31;
  localparam logic [4:0] HDR_END_16  = 5'd15;
  localparam logic [4:0] M3_HDR_MID  = 5'd7;

  // one entry of the queue: up to three result bytes, first one at index 0
  typedef struct packed {
    logic [2:0][7:0] data;
    logic [1:0]      count;
    logic            last;
    logic            empty;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

endpackage

[src/lpe_front.sv]
// front end: carrier accept, header gathering and payload grouping
`timescale 1ns / 1ps
`include "lsb_payload_extractor_top_assert.svh"

module lpe_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic [1:0]           bits_per_carrier_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [7:0]           carrier_byte_i,
  input  lpe_pkg::fifo_status_t fifo_st_i,
  output logic                 push_o,
  output lpe_pkg::cmd_t        cmd_o
);

  logic [1:0]  bpc_q, bpc_d;
  logic        in_payload_q, in_payload_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [23:0] bg_q, bg_d;
  logic [31:0] hdr_q, hdr_d;
  logic [31:0] bl_q, bl_d;

  logic [1:0]  mode;
  logic [23:0] bg_shift;
  logic [2:0]  grp_end;
  logic        group_done;
  logic [4:0]  hdr_end;
  logic [31:0] hdr_push;
  logic [1:0]  n_out;
  logic        is_last;
  logic [31:0] bl_next;
  logic        accept;

  assign in_stall_o = fifo_st_i.full;
  assign accept     = in_valid_i && !fifo_st_i.full;

  assign mode = (bpc_q == 2'd0) ? lpe_pkg::MODE_1BIT : bpc_q;

  always_comb begin
    case (mode)
      lpe_pkg::MODE_2BIT: bg_shift = {bg_q[21:0], carrier_byte_i[1:0]};
      lpe_pkg::MODE_3BIT: bg_shift = {bg_q[20:0], carrier_byte_i[2:0]};
      default:            bg_shift = {bg_q[22:0], carrier_byte_i[0]};
    endcase
  end

  assign grp_end    = (mode == lpe_pkg::MODE_2BIT) ? lpe_pkg::GROUP_END_4
                                                   : lpe_pkg::GROUP_END_8;
  assign group_done = (cnt_q[2:0] & grp_end) == grp_end;
  assign hdr_end    = (mode == lpe_pkg::MODE_1BIT) ? lpe_pkg::HDR_END_32
                                                   : lpe_pkg::HDR_END_16;

  // header bytes enter at the top, so the first byte ends up lowest
  always_comb begin
    hdr_push = hdr_q;
    if (group_done) begin
      if (mode == lpe_pkg::MODE_3BIT) begin
        if (cnt_q == lpe_pkg::M3_HDR_MID) begin
          hdr_push = {bg_shift[7:0], bg_shift[15:8], bg_shift[23:16], hdr_q[31:24]};
        end else begin
          hdr_push = {bg_shift[23:16], hdr_q[31:8]};
        end
      end else begin
        hdr_push = {bg_shift[7:0], hdr_q[31:8]};
      end
    end
  end

  always_comb begin
    if (mode == lpe_pkg::MODE_3BIT) begin
      n_out = (bl_q[31:2] == 30'd0 && bl_q[1:0] != 2'd3) ? bl_q[1:0] : 2'd3;
    end else begin
      n_out = 2'd1;
    end
  end

  assign is_last = (bl_q == {30'd0, n_out});
  assign bl_next = bl_q - {30'd0, n_out};

  always_comb begin
    bpc_d        = bpc_q;
    in_payload_d = in_payload_q;
    cnt_d        = cnt_q;
    bg_d         = bg_q;
    hdr_d        = hdr_q;
    bl_d         = bl_q;
    push_o       = 1'b0;
    cmd_o        = '0;
    if (cfg_valid_i) begin
      bpc_d        = bits_per_carrier_i;
      in_payload_d = 1'b0;
      cnt_d        = '0;
      bg_d         = '0;
      hdr_d        = '0;
      bl_d         = '0;
    end else if (accept) begin
      if (!in_payload_q) begin
        if (cnt_q == hdr_end) begin
          cnt_d = '0;
          bg_d  = '0;
          hdr_d = '0;
          if (hdr_push == 32'd0 || hdr_push[31]) begin
            // empty message
            push_o      = 1'b1;
            cmd_o.count = 2'd1;
            cmd_o.last  = 1'b1;
            cmd_o.empty = 1'b1;
          end else begin
            in_payload_d = 1'b1;
            bl_d         = hdr_push;
          end
        end else begin
          hdr_d = hdr_push;
          bg_d  = group_done ? 24'd0 : bg_shift;
          cnt_d = 5'(cnt_q + 5'd1);
        end
      end else if (!group_done) begin
        bg_d  = bg_shift;
        cnt_d = 5'(cnt_q + 5'd1);
      end else begin
        push_o      = 1'b1;
        cmd_o.count = n_out;
        cmd_o.last  = is_last;
        if (mode == lpe_pkg::MODE_3BIT) begin
          cmd_o.data[0] = bg_shift[23:16];
          cmd_o.data[1] = bg_shift[15:8];
          cmd_o.data[2] = bg_shift[7:0];
        end else begin
          cmd_o.data[0] = bg_shift[7:0];
        end
        bg_d  = '0;
        cnt_d = '0;
        bl_d  = bl_next;
        if (is_last) begin
          in_payload_d = 1'b0;
          hdr_d        = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpc_q        <= lpe_pkg::MODE_1BIT;
      in_payload_q <= 1'b0;
      cnt_q        <= '0;
      bg_q         <= '0;
      hdr_q        <= '0;
      bl_q         <= '0;
    end else begin
      bpc_q        <= bpc_d;
      in_payload_q <= in_payload_d;
      cnt_q        <= cnt_d;
      bg_q         <= bg_d;
      hdr_q        <= hdr_d;
      bl_q         <= bl_d;
    end
  end

  `LPE_ASSERT_NOW(a_payload_has_bytes, clk_i, rst_ni, in_payload_q, bl_q != 32'd0, "payload phase with no bytes left")
  `LPE_ASSERT_NOW(a_header_no_bytes, clk_i, rst_ni, !in_payload_q, bl_q == 32'd0, "bytes left during header phase")
  `LPE_ASSERT_NOW(a_push_nonzero, clk_i, rst_ni, push_o, cmd_o.count != 2'd0, "queue entry with no results")

endmodule

[src/lpe_fifo.sv]
// short queue of result groups between front and back end
`timescale 1ns / 1ps
`include "lsb_payload_extractor_top_assert.svh"

module lpe_fifo #(
  parameter int unsigned DEPTH = lpe_pkg::FIFO_DEPTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  lpe_pkg::cmd_t         cmd_i,
  input  logic                  pop_i,
  output lpe_pkg::cmd_t         head_o,
  output lpe_pkg::fifo_status_t st_o
);

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  lpe_pkg::cmd_t   mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign st_o.full  = (cnt_q == CntW'(DEPTH));
  assign st_o.empty = (cnt_q == '0);
  assign head_o     = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : PtrW'(wr_ptr_q + 1'b1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : PtrW'(rd_ptr_q + 1'b1);
    end
    if (push_i && !pop_i) begin
      cnt_d = CntW'(cnt_q + 1'b1);
    end else if (!push_i && pop_i) begin
      cnt_d = CntW'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  `LPE_ASSERT_NOW(a_no_push_full, clk_i, rst_ni, push_i, !st_o.full, "push into full queue")
  `LPE_ASSERT_NOW(a_no_pop_empty, clk_i, rst_ni, pop_i, !st_o.empty, "pop from empty queue")
  `LPE_ASSERT_NEXT(a_count_up, clk_i, rst_ni, push_i && !pop_i, cnt_q == $past(cnt_q) + 1'b1, "queue count did not follow push")

endmodule

[src/lpe_back.sv]
// back end: splits queued groups into single results behind an output register
`timescale 1ns / 1ps
`include "lsb_payload_extractor_top_assert.svh"

module lpe_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lpe_pkg::fifo_status_t fifo_st_i,
  input  lpe_pkg::cmd_t         head_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [7:0]            data_byte_o,
  output logic                  last_o,
  output logic                  empty_res_o
);

  logic [1:0] idx_q, idx_d;
  logic       valid_q, valid_d;
  logic [7:0] data_q, data_d;
  logic       last_q, last_d;
  logic       empty_q, empty_d;
  logic       load;
  logic       at_end;

  assign load   = !fifo_st_i.empty && (!valid_q || !out_stall_i);
  assign at_end = (idx_q == 2'(head_i.count - 2'd1));
  assign pop_o  = load && at_end;

  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    data_d  = data_q;
    last_d  = last_q;
    empty_d = empty_q;
    if (load) begin
      valid_d = 1'b1;
      data_d  = head_i.data[idx_q];
      last_d  = head_i.last && at_end;
      empty_d = head_i.empty;
      idx_d   = at_end ? 2'd0 : 2'(idx_q + 2'd1);
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q  <= data_d;
    last_q  <= last_d;
    empty_q <= empty_d;
  end

  assign out_valid_o = valid_q;
  assign data_byte_o = data_q;
  assign last_o      = last_q;
  assign empty_res_o = empty_q;

  `LPE_ASSERT_NOW(a_idx_in_group, clk_i, rst_ni, !fifo_st_i.empty, idx_q < head_i.count, "result index beyond group")
  `LPE_ASSERT_NOW(a_idx_idle, clk_i, rst_ni, fifo_st_i.empty, idx_q == 2'd0, "result index not reset on empty queue")

endmodule

[src/lsb_payload_extractor_top.sv]
// One carrier byte is taken per cycle while in_stall_o is low; in_stall_o
// rises only when the result queue (FIFO_DEPTH groups) is full. Results
// leave one per cycle while out_stall_i is low, from an output register
// loaded from the queue, so mode 3, which yields up to three bytes per
// eight carriers, keeps up. After reset the block is in mode 1 and waits
// for a header; a write to bits_per_carrier_i (0 acts as 1) clears the
// front end message state, not queued groups. A zero or negative length
// gives one result with empty_res_o and last_o set.
`timescale 1ns / 1ps

module lsb_payload_extractor_top #(
  parameter int unsigned FIFO_DEPTH = lpe_pkg::FIFO_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] bits_per_carrier_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] carrier_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] data_byte_o,
  output logic       last_o,
  output logic       empty_res_o
);

  lpe_pkg::fifo_status_t fifo_st;
  lpe_pkg::cmd_t         push_cmd;
  lpe_pkg::cmd_t         head_cmd;
  logic                  push;
  logic                  pop;

  assign cfg_ready_o = 1'b1;

  lpe_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .bits_per_carrier_i (bits_per_carrier_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .carrier_byte_i     (carrier_byte_i),
    .fifo_st_i          (fifo_st),
    .push_o             (push),
    .cmd_o              (push_cmd)
  );

  lpe_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (push_cmd),
    .pop_i  (pop),
    .head_o (head_cmd),
    .st_o   (fifo_st)
  );

  lpe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fifo_st_i   (fifo_st),
    .head_i      (head_cmd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .data_byte_o (data_byte_o),
    .last_o      (last_o),
    .empty_res_o (empty_res_o)
  );

endmodule
